// ===== rtl/pcs_pkg.sv =====
// Package for the precharge / contactor sequencer.
// Holds mode and status codes, sequence phases, relay bit positions and the state struct.
// No dependencies.
package pcs_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_DRIVE  = 2'd1,
    MODE_CHARGE = 2'd2,
    MODE_FAULT  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_NONE         = 3'd0,
    ST_DRIVE_GOOD   = 3'd1,
    ST_CHG_GOOD     = 3'd2,
    ST_CHG_COMPLETE = 3'd3,
    ST_DRIVE_FAULT  = 3'd4,
    ST_CHG_FAULT    = 3'd5
  } status_e;

  // Sequence phases; zero means the sequence is done.
  localparam logic [2:0] PH_DONE   = 3'd0;
  localparam logic [2:0] PH_STEP_1 = 3'd1;
  localparam logic [2:0] PH_STEP_2 = 3'd2;
  localparam logic [2:0] PH_STEP_3 = 3'd3;
  localparam logic [2:0] PH_STEP_4 = 3'd4;

  // Relay drive bit positions.
  localparam int unsigned RLY_NEG = 0;
  localparam int unsigned RLY_POS = 1;
  localparam int unsigned RLY_PRE = 2;
  localparam int unsigned RLY_CHG = 3;

  localparam int unsigned TimeW = 16;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PRECHARGE  = 2'd0;
  localparam logic [1:0] CFG_SETTLE     = 2'd1;
  localparam logic [1:0] CFG_FAULT_HOLD = 2'd2;

  localparam logic [TimeW-1:0] PRECHARGE_RST  = 16'd50;
  localparam logic [TimeW-1:0] SETTLE_RST     = 16'd1;
  localparam logic [TimeW-1:0] FAULT_HOLD_RST = 16'd50;

  typedef struct packed {
    mode_e            mode;
    logic [2:0]       phase;
    logic [TimeW-1:0] wait_cnt;
    status_e          status;
    logic [3:0]       relay;
  } seq_state_t;

  typedef struct packed {
    logic [TimeW-1:0] precharge_ticks;
    logic [TimeW-1:0] settle_ticks;
    logic [TimeW-1:0] fault_hold_ticks;
  } seq_cfg_t;

endpackage

// ===== rtl/pcs_step.sv =====
// Next-state logic of the sequencer for one tick.
// Depends on pcs_pkg.
module pcs_step (
  input  pcs_pkg::seq_state_t cur_i,
  input  pcs_pkg::seq_cfg_t   cfg_i,
  input  logic                ce_i,
  input  logic                de_i,
  input  logic                cp_i,
  output pcs_pkg::seq_state_t nxt_o
);
  import pcs_pkg::*;

  logic running;
  logic wait_zero;

  assign wait_zero = (cur_i.wait_cnt == '0);
  assign running   = ((cur_i.phase == PH_DONE) || (cur_i.phase > PH_STEP_2)) && wait_zero;

  always_comb begin
    nxt_o = cur_i;
    case (cur_i.mode)
      MODE_IDLE: begin
        nxt_o.relay = '0;
        if (ce_i && de_i && !cp_i) begin
          nxt_o.mode     = MODE_DRIVE;
          nxt_o.phase    = PH_STEP_1;
          nxt_o.wait_cnt = '0;
        end else if (ce_i && cp_i) begin
          nxt_o.mode     = MODE_CHARGE;
          nxt_o.phase    = PH_STEP_1;
          nxt_o.wait_cnt = '0;
        end
      end
      MODE_DRIVE: begin
        if (!(ce_i && de_i)) begin
          nxt_o.relay    = '0;
          nxt_o.mode     = MODE_FAULT;
          nxt_o.phase    = PH_DONE;
          nxt_o.wait_cnt = cfg_i.fault_hold_ticks;
          nxt_o.status   = ST_DRIVE_FAULT;
        end else if (!wait_zero) begin
          nxt_o.wait_cnt = cur_i.wait_cnt - 1'b1;
        end else begin
          case (cur_i.phase)
            PH_STEP_1: begin
              nxt_o.relay[RLY_NEG] = 1'b1;
              nxt_o.wait_cnt       = cfg_i.settle_ticks;
              nxt_o.phase          = PH_STEP_2;
            end
            PH_STEP_2: begin
              nxt_o.relay[RLY_PRE] = 1'b1;
              nxt_o.wait_cnt       = cfg_i.precharge_ticks;
              nxt_o.phase          = PH_STEP_3;
            end
            PH_STEP_3: begin
              nxt_o.relay[RLY_POS] = 1'b1;
              nxt_o.wait_cnt       = cfg_i.settle_ticks;
              nxt_o.phase          = PH_STEP_4;
            end
            PH_STEP_4: begin
              nxt_o.relay[RLY_PRE] = 1'b0;
              nxt_o.wait_cnt       = cfg_i.settle_ticks;
              nxt_o.phase          = PH_DONE;
            end
            default: begin
              nxt_o.phase  = PH_DONE;
              nxt_o.status = ST_DRIVE_GOOD;
            end
          endcase
        end
      end
      MODE_CHARGE: begin
        if (running) begin
          nxt_o.phase = PH_DONE;
          if (!ce_i) begin
            nxt_o.relay    = '0;
            nxt_o.mode     = MODE_FAULT;
            nxt_o.wait_cnt = cfg_i.fault_hold_ticks;
            nxt_o.status   = ST_CHG_FAULT;
          end else if (!cp_i) begin
            // charger gone: charge finished, drop back to idle
            nxt_o.relay  = '0;
            nxt_o.status = ST_CHG_COMPLETE;
            nxt_o.mode   = MODE_IDLE;
          end else begin
            nxt_o.status = ST_CHG_GOOD;
          end
        end else if (!(ce_i && cp_i)) begin
          nxt_o.relay    = '0;
          nxt_o.mode     = MODE_FAULT;
          nxt_o.phase    = PH_DONE;
          nxt_o.wait_cnt = cfg_i.fault_hold_ticks;
          nxt_o.status   = ST_CHG_FAULT;
        end else if (!wait_zero) begin
          nxt_o.wait_cnt = cur_i.wait_cnt - 1'b1;
        end else if (cur_i.phase == PH_STEP_1) begin
          nxt_o.relay[RLY_NEG] = 1'b1;
          nxt_o.wait_cnt       = cfg_i.settle_ticks;
          nxt_o.phase          = PH_STEP_2;
        end else begin
          nxt_o.relay[RLY_CHG] = 1'b1;
          nxt_o.wait_cnt       = cfg_i.settle_ticks;
          nxt_o.phase          = PH_DONE;
        end
      end
      default: begin
        nxt_o.relay = '0;
        if (!wait_zero) begin
          nxt_o.wait_cnt = cur_i.wait_cnt - 1'b1;
        end else if (ce_i && de_i) begin
          nxt_o.mode   = MODE_IDLE;
          nxt_o.phase  = PH_DONE;
          nxt_o.status = ST_DRIVE_GOOD;
        end
      end
    endcase
  end

endmodule

// ===== rtl/precharge_contactor_sequencer.sv =====
// Precharge / contactor sequencer top level: input register, state, result register.
// Depends on pcs_pkg and pcs_step.
// A tick's request waits in the input register; its result is then registered for m_axis.
// Throughput: one tick per cycle while m_axis_tready holds; the input register takes a request while a result waits.
// The state update is one pass of the pcs_step next-state logic between the registers.
// Reset: relays open, mode idle, status none, timing registers 50 / 1 / 50.
module precharge_contactor_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] charge_enable, [1] discharge_enable, [2] charger_present, [7:3] zero
  input  logic [7:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] relay_negative, [1] relay_positive, [2] relay_prechg, [3] relay_chg,
  // [5:4] mode_out, [8:6] status_out, [15:9] zero
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import pcs_pkg::*;

  logic       in_valid_q;
  logic [2:0] in_data_q;
  logic       out_valid_q;
  logic [8:0] out_data_q;
  logic       advance;

  seq_state_t st_q, st_d;
  seq_cfg_t   cfg_q;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.precharge_ticks  <= PRECHARGE_RST;
      cfg_q.settle_ticks     <= SETTLE_RST;
      cfg_q.fault_hold_ticks <= FAULT_HOLD_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PRECHARGE:  cfg_q.precharge_ticks  <= cfg_data_i;
        CFG_SETTLE:     cfg_q.settle_ticks     <= cfg_data_i;
        CFG_FAULT_HOLD: cfg_q.fault_hold_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata[2:0];
    end
  end

  pcs_step u_step (
    .cur_i (st_q),
    .cfg_i (cfg_q),
    .ce_i  (in_data_q[0]),
    .de_i  (in_data_q[1]),
    .cp_i  (in_data_q[2]),
    .nxt_o (st_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode     <= MODE_IDLE;
      st_q.phase    <= PH_DONE;
      st_q.wait_cnt <= '0;
      st_q.status   <= ST_NONE;
      st_q.relay    <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {st_d.status, st_d.mode, st_d.relay};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_data_q};

`ifndef ASSERT_OFF
  a_fault_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.mode == MODE_FAULT) |-> (st_q.relay == '0))
    else $error("relay closed in fault mode");

  a_idle_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.mode == MODE_IDLE) |-> (st_q.relay == '0))
    else $error("relay closed in idle mode");

  a_pos_needs_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.relay[RLY_POS] |-> st_q.relay[RLY_NEG])
    else $error("positive contactor closed without negative");

  a_chg_pos_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_q.relay[RLY_POS] && st_q.relay[RLY_CHG]))
    else $error("charge and positive relays closed together");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_valid_q && (out_data_q[3:0] == st_q.relay)))
    else $error("result register does not match state after update");
`endif

endmodule

// ===== tb/sv/precharge_contactor_sequencer_tb.sv =====
`timescale 1ns / 1ps
// Testbench for precharge_contactor_sequencer: a directed table, then random tick streams
// under several timing settings, results checked against this file's model or table pins.
// Depends on pcs_pkg and the RTL top level.
module precharge_contactor_sequencer_tb;
  import pcs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned LONG_HOLD   = 400;
  // register index with no register behind it
  localparam logic [1:0]  CFG_SPARE   = 2'd3;

  // result layout of m_axis_tdata, lowest bit last
  typedef struct packed {
    logic [6:0] pad;
    status_e    status;
    mode_e      mode;
    logic       chg;
    logic       pre;
    logic       pos;
    logic       neg;
  } result_t;

  typedef struct {
    bit          is_reg;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
    logic        ce;
    logic        de;
    logic        cp;
    bit          pinned;
    result_t     pin;
  } dir_row_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata   = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i    = '0;
  logic [15:0] cfg_data_i     = '0;

  int unsigned src_idle_pct = 15;
  int unsigned dst_idle_pct = 73;
  int unsigned hold_token   = 0;
  int unsigned hold_seen    = 0;
  int unsigned stall_left   = 0;
  int unsigned cycle_count  = 0;
  int unsigned ticks_sent   = 0;
  int unsigned mismatch_count = 0;

  seq_state_t seq    = '0;
  seq_cfg_t   timing = '{PRECHARGE_RST, SETTLE_RST, FAULT_HOLD_RST};
  result_t    predicted_outputs[$];

  precharge_contactor_sequencer uut (.*);

  always #6 clk_i = ~clk_i;

  // ---------------- sequencer model ----------------

  function automatic void trip(input status_e why);
    seq.relay    = '0;
    seq.mode     = MODE_FAULT;
    seq.phase    = PH_DONE;
    seq.wait_cnt = timing.fault_hold_ticks;
    seq.status   = why;
  endfunction

  function automatic result_t sequencer_next(input logic ce, input logic de, input logic cp);
    result_t r;
    logic    running;
    case (seq.mode)
      MODE_IDLE: begin
        seq.relay = '0;
        if (ce && de && !cp) begin
          seq.mode = MODE_DRIVE; seq.phase = PH_STEP_1; seq.wait_cnt = '0;
        end else if (ce && cp) begin
          seq.mode = MODE_CHARGE; seq.phase = PH_STEP_1; seq.wait_cnt = '0;
        end
      end
      MODE_DRIVE: begin
        if (!(ce && de)) begin
          trip(ST_DRIVE_FAULT);
        end else if (seq.wait_cnt != '0) begin
          seq.wait_cnt = seq.wait_cnt - 1'b1;
        end else begin
          case (seq.phase)
            PH_STEP_1: begin
              seq.relay[RLY_NEG] = 1'b1; seq.wait_cnt = timing.settle_ticks;
              seq.phase = PH_STEP_2;
            end
            PH_STEP_2: begin
              seq.relay[RLY_PRE] = 1'b1; seq.wait_cnt = timing.precharge_ticks;
              seq.phase = PH_STEP_3;
            end
            PH_STEP_3: begin
              seq.relay[RLY_POS] = 1'b1; seq.wait_cnt = timing.settle_ticks;
              seq.phase = PH_STEP_4;
            end
            PH_STEP_4: begin
              seq.relay[RLY_PRE] = 1'b0; seq.wait_cnt = timing.settle_ticks;
              seq.phase = PH_DONE;
            end
            default: begin
              seq.phase = PH_DONE; seq.status = ST_DRIVE_GOOD;
            end
          endcase
        end
      end
      MODE_CHARGE: begin
        running = (seq.phase == PH_DONE || seq.phase > PH_STEP_2) && seq.wait_cnt == '0;
        if (running) begin
          seq.phase = PH_DONE;
          if (!ce) begin
            trip(ST_CHG_FAULT);
          end else if (!cp) begin
            // charger gone while enabled: charge complete, back to idle
            seq.relay = '0; seq.status = ST_CHG_COMPLETE; seq.mode = MODE_IDLE;
          end else begin
            seq.status = ST_CHG_GOOD;
          end
        end else if (!(ce && cp)) begin
          trip(ST_CHG_FAULT);
        end else if (seq.wait_cnt != '0) begin
          seq.wait_cnt = seq.wait_cnt - 1'b1;
        end else if (seq.phase == PH_STEP_1) begin
          seq.relay[RLY_NEG] = 1'b1; seq.wait_cnt = timing.settle_ticks; seq.phase = PH_STEP_2;
        end else begin
          seq.relay[RLY_CHG] = 1'b1; seq.wait_cnt = timing.settle_ticks; seq.phase = PH_DONE;
        end
      end
      default: begin
        seq.relay = '0;
        if (seq.wait_cnt != '0) begin
          seq.wait_cnt = seq.wait_cnt - 1'b1;
        end else if (ce && de) begin
          seq.mode = MODE_IDLE; seq.phase = PH_DONE; seq.status = ST_DRIVE_GOOD;
        end
      end
    endcase
    r        = '0;
    r.neg    = seq.relay[RLY_NEG];
    r.pos    = seq.relay[RLY_POS];
    r.pre    = seq.relay[RLY_PRE];
    r.chg    = seq.relay[RLY_CHG];
    r.mode   = seq.mode;
    r.status = seq.status;
    return r;
  endfunction

  // ---------------- checking ----------------

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [6:0] got, input logic [6:0] want);
    if (got !== want) report_error($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata);
      if (predicted_outputs.size() == 0) begin
        report_error($sformatf("result 0x%04h with no request outstanding", m_axis_tdata));
      end else begin
        want = predicted_outputs.pop_front();
        check_field("relay_negative", got.neg, want.neg);
        check_field("relay_positive", got.pos, want.pos);
        check_field("relay_prechg", got.pre, want.pre);
        check_field("relay_chg", got.chg, want.chg);
        check_field("mode_out", got.mode, want.mode);
        check_field("status_out", got.status, want.status);
        check_field("tdata padding", got.pad, want.pad);
      end
    end
  end

  // receiver: random backpressure, plus a long hold-off whenever the token moves
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (hold_token != hold_seen) begin
      hold_seen     <= hold_token;
      stall_left    <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------- stimulus ----------------

  task automatic offer_tick(input logic ce, input logic de, input logic cp,
                            input bit pinned, input result_t pin);
    result_t want;
    cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, cp, de, ce};
    do @(posedge clk_i); while (!s_axis_tready);
    want = sequencer_next(ce, de, cp);
    predicted_outputs.push_back(pinned ? pin : want);
    ticks_sent++;
  endtask

  // stop sending and wait until every result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    cfg_valid_i   <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_PRECHARGE:  timing.precharge_ticks  = val;
      CFG_SETTLE:     timing.settle_ticks     = val;
      CFG_FAULT_HOLD: timing.fault_hold_ticks = val;
      default: ;
    endcase
  endtask

  task automatic random_ticks(input int unsigned count);
    int unsigned stop_at;
    int unsigned len;
    int unsigned k;
    logic        ce;
    logic        de;
    logic        cp;
    stop_at = ticks_sent + count;
    while (ticks_sent < stop_at) begin
      len = $urandom_range(30, 3);
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          // drive run; charger off on the first tick so idle picks drive
          for (k = 0; k < len; k++) begin
            {ce, de} = 2'b11;
            cp = (k == 0) ? 1'b0 : 1'($urandom_range(1));
            if ($urandom_range(15) == 0) {ce, de} = 2'($urandom_range(2));
            offer_tick(ce, de, cp, 1'b0, '0);
            if (!(ce && de)) break;
          end
        end
        4, 5, 6: begin
          // charge run, ending in charger removal, enable loss or just stopping
          for (k = 0; k < len; k++) begin
            ce = 1'b1;
            cp = 1'b1;
            de = 1'($urandom_range(1));
            if (k == len - 1 || $urandom_range(19) == 0) begin
              case ($urandom_range(2))
                0: cp = 1'b0;
                1: ce = 1'b0;
                default: ;
              endcase
            end
            offer_tick(ce, de, cp, 1'b0, '0);
            if (!(ce && cp)) break;
          end
        end
        default: begin
          repeat ($urandom_range(6, 1))
            offer_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                       1'b0, '0);
        end
      endcase
    end
  endtask

  task automatic run_phase(input logic [15:0] pre_t, input logic [15:0] settle_t,
                           input logic [15:0] hold_t, input int unsigned src_pct,
                           input int unsigned dst_pct, input int unsigned count,
                           input bit pressure);
    drain();
    write_reg(CFG_PRECHARGE, pre_t);
    write_reg(CFG_SETTLE, settle_t);
    write_reg(CFG_FAULT_HOLD, hold_t);
    src_idle_pct = src_pct;
    dst_idle_pct <= dst_pct;
    if (pressure) begin
      // receiver stalls long while ticks keep coming, later the sender waits for all
      hold_token <= hold_token + 1;
      random_ticks(count / 2);
      drain();
      random_ticks(count - count / 2);
    end else begin
      random_ticks(count);
    end
  endtask

  function automatic dir_row_t tick_row(input logic ce, input logic de, input logic cp);
    dir_row_t row;
    row        = '{default: '0};
    row.ce     = ce;
    row.de     = de;
    row.cp     = cp;
    return row;
  endfunction

  // rows whose result is plain: all relays open in the given mode and status
  function automatic dir_row_t pinned_row(input logic ce, input logic de, input logic cp,
                                          input mode_e m, input status_e s);
    dir_row_t row;
    row            = tick_row(ce, de, cp);
    row.pinned     = 1'b1;
    row.pin        = '0;
    row.pin.mode   = m;
    row.pin.status = s;
    return row;
  endfunction

  function automatic dir_row_t reg_row(input logic [1:0] idx, input logic [15:0] val);
    dir_row_t row;
    row         = '{default: '0};
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  initial begin
    dir_row_t plan[$];
    plan = '{
      pinned_row(0, 0, 0, MODE_IDLE, ST_NONE),
      reg_row(CFG_FAULT_HOLD, 16'd0),
      reg_row(CFG_SPARE, 16'hFFFF),
      pinned_row(1, 1, 0, MODE_DRIVE, ST_NONE),
      tick_row(1, 1, 0),
      tick_row(1, 1, 1),
      tick_row(1, 1, 0),
      pinned_row(1, 0, 0, MODE_FAULT, ST_DRIVE_FAULT),
      tick_row(0, 1, 0),
      pinned_row(1, 1, 0, MODE_IDLE, ST_DRIVE_GOOD),
      reg_row(CFG_PRECHARGE, 16'd0),
      reg_row(CFG_SETTLE, 16'd0),
      tick_row(1, 0, 1),
      tick_row(1, 0, 1),
      tick_row(1, 1, 1),
      tick_row(1, 0, 1),
      pinned_row(1, 0, 0, MODE_IDLE, ST_CHG_COMPLETE),
      tick_row(1, 1, 1),
      pinned_row(0, 1, 1, MODE_FAULT, ST_CHG_FAULT),
      tick_row(0, 1, 1),
      tick_row(1, 1, 0),
      tick_row(1, 1, 0),
      tick_row(1, 1, 0),
      tick_row(1, 1, 0),
      tick_row(1, 1, 0),
      tick_row(1, 1, 0),
      tick_row(1, 1, 1),
      tick_row(0, 0, 1),
      tick_row(0, 0, 0),
      tick_row(1, 1, 1),
      tick_row(0, 1, 0)
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        offer_tick(plan[i].ce, plan[i].de, plan[i].cp, plan[i].pinned, plan[i].pin);
      end
    end

    run_phase(16'd3, 16'd1, 16'd2, 15, 73, 200, 1'b0);
    run_phase(16'hFFFF, 16'd2, 16'd1, 73, 15, 150, 1'b0);
    run_phase(16'd2, 16'd3, 16'd3, 0, 0, 200, 1'b1);
    run_phase(16'd1, 16'hFFFF, 16'hFFFF, 0, 0, 50, 1'b0);
    drain();

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
